// ===== hdl/cmb_pkg.sv =====
package cmb_pkg;

  localparam int LVL_W       = 12;
  localparam int MASK_W      = 8;
  localparam int SUM_W       = 15;
  localparam int CNT_W       = 4;
  localparam int TEMP_W      = 16;
  localparam int ID_W        = 11;
  localparam int PAYLOAD_W   = 64;
  localparam int ADDR_W      = 6;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  // request kinds
  localparam logic [1:0] REQ_FRAME   = 2'd0;
  localparam logic [1:0] REQ_BALANCE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_MODULE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_IGNORE_LEVEL   = 2'd1;

  localparam logic [ID_W-1:0] ID_CELLS_LO = 11'h060;
  localparam logic [ID_W-1:0] ID_CELLS_HI = 11'h070;
  localparam logic [ID_W-1:0] ID_TEMP     = 11'h0E0;

  localparam logic [ADDR_W-1:0] ADDR_WIDE_MIN = 6'd2;
  localparam logic [ADDR_W-1:0] ADDR_WIDE_MAX = 6'd11;

  localparam logic [LVL_W-1:0]  LOW_LIMIT   = 12'd4000;
  localparam logic [LVL_W:0]    SPREAD_GAP  = 13'd40;
  localparam logic [LVL_W:0]    KEEP_MARGIN = 13'd20;
  localparam logic [MASK_W-1:0] MASK_FULL8  = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_FULL6  = 8'h3F;

  typedef struct packed {
    logic eq_max;
    logic keep;
  } cmb_flags_t;

  typedef struct packed {
    logic             qual;
    logic             lowcand;
    logic [LVL_W-1:0] level;
  } cmb_lstat_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature_raw;
    logic [CNT_W-1:0]  cell_count;
    logic [SUM_W-1:0]  level_sum;
    logic [LVL_W-1:0]  high_level;
    logic              low_valid;
    logic [LVL_W-1:0]  low_level;
    logic [MASK_W-1:0] balance_mask;
  } cmb_result_t;

endpackage

// ===== hdl/cmb_lane.sv =====
module cmb_lane
  import cmb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic                 frame_lo,
  input  logic                 frame_hi,
  input  logic                 eight,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic [LVL_W-1:0]     ignore_level,
  input  logic [LVL_W-1:0]     pack_min,
  input  logic [LVL_W-1:0]     pack_max,
  input  logic                 mask_bit,
  input  logic                 snap_en,
  output cmb_flags_t           flags,
  output cmb_lstat_t           lstat,
  output logic [LVL_W-1:0]     level
);

  localparam logic [3:0] K = 4'(IDX);

  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_nxt;
  cmb_lstat_t       lstat_r;
  logic [3:0]       per;
  logic             in_first;
  logic             in_second;
  logic [1:0]       j;
  logic             hit;
  logic [5:0]       base;

  assign per       = eight ? 4'd4 : 4'd3;
  assign in_first  = K < per;
  assign in_second = (K >= per) && (K < {per[2:0], 1'b0});
  assign j         = frame_lo ? K[1:0] : 2'(K - per);
  assign hit       = (frame_lo && in_first) || (frame_hi && in_second);
  assign base      = {j, 4'b0000};
  // high byte keeps only its low nibble, low byte follows it
  assign level_nxt = {payload[base +: 4], payload[base + 6'd8 +: 8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (wr_en && hit && (level_nxt != '0)) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_en) begin
      lstat_r.qual    <= level_r > ignore_level;
      lstat_r.lowcand <= (level_r > ignore_level) && !mask_bit;
      lstat_r.level   <= level_r;
    end
  end

  assign flags.eq_max = level_r == pack_max;
  assign flags.keep   = ({1'b0, level_r} + KEEP_MARGIN) > {1'b0, pack_min};
  assign lstat        = lstat_r;
  assign level        = level_r;

endmodule

// ===== hdl/cmb_merge.sv =====
module cmb_merge
  import cmb_pkg::*;
#(
  parameter int CELLS = 8
) (
  input  cmb_flags_t       flags [CELLS],
  input  logic [LVL_W-1:0] levels [CELLS],
  input  logic [CELLS-1:0] mask,
  input  logic             spread,
  output logic [CELLS-1:0] mask_nxt
);

  localparam int IDX_W = $clog2(CELLS);

  logic [CELLS-1:0]  m;
  logic              skip;
  logic              look;
  logic [LVL_W-1:0]  best;
  logic [IDX_W-1:0]  best_idx;
  logic              found;
  logic [MASK_W-1:0] m8;

  always_comb begin
    m        = mask;
    skip     = 1'b0;
    look     = 1'b1;
    best     = LOW_LIMIT;
    best_idx = '0;
    found    = 1'b0;
    for (int k = 0; k < CELLS; k++) begin
      look = 1'b1;
      if (spread) begin
        if (skip) begin
          // cell after a fresh start is passed over
          skip = 1'b0;
        end else if (mask[k]) begin
          m[k] = flags[k].keep;
        end else if (flags[k].eq_max) begin
          m[k] = 1'b1;
          skip = 1'b1;
          // the started cell itself stays out of the lowest search
          look = 1'b0;
        end
      end else begin
        m[k] = flags[k].eq_max;
      end
      if (look && (levels[k] != '0) && (levels[k] < best)) begin
        best     = levels[k];
        best_idx = IDX_W'(k);
        found    = 1'b1;
      end
    end
    m8 = MASK_W'(m);
    mask_nxt = m;
    if (found && ((m8 == MASK_FULL8) || (m8 == MASK_FULL6))) begin
      mask_nxt[best_idx] = 1'b0;
    end
  end

endmodule

// ===== hdl/cmb_stats.sv =====
module cmb_stats
  import cmb_pkg::*;
#(
  parameter int CELLS = 8
) (
  input  logic              clk,
  input  logic              snap_en,
  input  logic              load_en,
  input  logic [CELLS-1:0]  mask,
  input  logic [TEMP_W-1:0] temp,
  input  cmb_lstat_t        lstat [CELLS],
  output cmb_result_t       result
);

  logic [CELLS-1:0]  mask_r;
  logic [TEMP_W-1:0] temp_r;
  cmb_result_t       result_r;
  cmb_result_t       result_nxt;

  always_ff @(posedge clk) begin
    if (snap_en) begin
      mask_r <= mask;
      temp_r <= temp;
    end
    if (load_en) begin
      result_r <= result_nxt;
    end
  end

  always_comb begin
    result_nxt                 = '0;
    result_nxt.balance_mask    = MASK_W'(mask_r);
    result_nxt.temperature_raw = temp_r;
    for (int k = 0; k < CELLS; k++) begin
      if (lstat[k].qual) begin
        if (lstat[k].lowcand &&
            (!result_nxt.low_valid || (lstat[k].level < result_nxt.low_level))) begin
          result_nxt.low_level = lstat[k].level;
          result_nxt.low_valid = 1'b1;
        end
        if (lstat[k].level > result_nxt.high_level) begin
          result_nxt.high_level = lstat[k].level;
        end
        result_nxt.level_sum  = result_nxt.level_sum + SUM_W'(lstat[k].level);
        result_nxt.cell_count = result_nxt.cell_count + 4'd1;
      end
    end
  end

  assign result = result_r;

endmodule

// ===== hdl/cell_monitor_with_balancing.sv =====
// channel | dir | tdata fields (low bit up)                         | tuser
// in_     | in  | frame_id, payload, pack_min, pack_max (104 bits)   | req_type
// out_    | out | balance_mask, low_level, low_valid, high_level,    | -
//         |     | level_sum, cell_count, temperature_raw (72 bits)   |
// cfg_    | in  | write enable, 2-bit index, 12-bit data             | -
//
// a word is taken every cycle while in_tready is high; cell levels, mask and
// temperature update at the accepting edge, so the next word sees them at once
// each result passes the snapshot stage, then the statistics merge into the
// output register
// reset (rst_n low, synchronous) clears levels, mask, temperature, registers
// and all valid flags; no clearing pass
// a stalled output holds the pipeline; in_tready drops only when all three
// stages are full and out_tready is low
module cell_monitor_with_balancing
  import cmb_pkg::*;
#(
  parameter int CELLS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // frame_id[10:0], payload[74:11], pack_min[86:75], pack_max[98:87], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // balance_mask[7:0], low_level[19:8], low_valid[20], high_level[32:21],
  // level_sum[47:33], cell_count[51:48], temperature_raw[67:52], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [LVL_W-1:0]       cfg_wdata
);

  logic [ADDR_W-1:0]    addr_r;
  logic [LVL_W-1:0]     ignore_r;
  logic [CELLS-1:0]     mask_r;
  logic [CELLS-1:0]     mask_nxt;
  logic [CELLS-1:0]     mask_bal;
  logic [TEMP_W-1:0]    temp_r;
  logic                 p0_r;
  logic                 p1_r;
  logic                 out_valid_r;

  logic [1:0]           req;
  logic [ID_W-1:0]      frame_id;
  logic [PAYLOAD_W-1:0] payload;
  logic [LVL_W-1:0]     pack_min;
  logic [LVL_W-1:0]     pack_max;
  logic                 accept;
  logic                 out_adv;
  logic                 p1_free;
  logic                 p0_free;
  logic                 is_frame;
  logic                 eight;
  logic                 spread;
  cmb_flags_t           flags  [CELLS];
  cmb_lstat_t           lstat  [CELLS];
  logic [LVL_W-1:0]     levels [CELLS];
  cmb_result_t          result;

  assign req      = in_tuser;
  assign frame_id = in_tdata[10:0];
  assign payload  = in_tdata[74:11];
  assign pack_min = in_tdata[86:75];
  assign pack_max = in_tdata[98:87];

  assign out_adv   = !out_valid_r || out_tready;
  assign p1_free   = !p1_r || out_adv;
  assign p0_free   = !p0_r || p1_free;
  assign in_tready = p0_free;
  assign accept    = in_tvalid && in_tready;

  assign is_frame = accept && (req == REQ_FRAME);
  assign eight    = (addr_r >= ADDR_WIDE_MIN) && (addr_r <= ADDR_WIDE_MAX);
  assign spread   = {1'b0, pack_max} > ({1'b0, pack_min} + SPREAD_GAP);

  for (genvar g = 0; g < CELLS; g++) begin : g_lane
    cmb_lane #(.IDX(g)) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr_en        (is_frame),
      .frame_lo     (frame_id == ID_CELLS_LO),
      .frame_hi     (frame_id == ID_CELLS_HI),
      .eight        (eight),
      .payload      (payload),
      .ignore_level (ignore_r),
      .pack_min     (pack_min),
      .pack_max     (pack_max),
      .mask_bit     (mask_r[g]),
      .snap_en      (p0_r && p1_free),
      .flags        (flags[g]),
      .lstat        (lstat[g]),
      .level        (levels[g])
    );
  end

  cmb_merge #(.CELLS(CELLS)) u_merge (
    .flags    (flags),
    .levels   (levels),
    .mask     (mask_r),
    .spread   (spread),
    .mask_nxt (mask_bal)
  );

  cmb_stats #(.CELLS(CELLS)) u_stats (
    .clk     (clk),
    .snap_en (p0_r && p1_free),
    .load_en (p1_r && out_adv),
    .mask    (mask_r),
    .temp    (temp_r),
    .lstat   (lstat),
    .result  (result)
  );

  always_comb begin
    mask_nxt = mask_r;
    if (accept) begin
      unique case (req)
        REQ_FRAME:   mask_nxt = mask_r;
        REQ_BALANCE: mask_nxt = mask_bal;
        REQ_CLEAR:   mask_nxt = '0;
        default:     mask_nxt = mask_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      ignore_r    <= '0;
      mask_r      <= '0;
      temp_r      <= '0;
      p0_r        <= 1'b0;
      p1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODULE_ADDRESS: addr_r   <= cfg_wdata[ADDR_W-1:0];
          CFG_IGNORE_LEVEL:   ignore_r <= cfg_wdata;
          default:            ;
        endcase
      end
      mask_r <= mask_nxt;
      if (is_frame && (frame_id == ID_TEMP)) begin
        // byte 6 is the high byte
        temp_r <= {payload[55:48], payload[63:56]};
      end
      if (p0_free) begin
        p0_r <= accept;
      end
      if (p1_free) begin
        p1_r <= p0_r;
      end
      if (out_adv) begin
        out_valid_r <= p1_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, result};

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (p0_r && p1_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full");

  a_clear_empties_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req == REQ_CLEAR)) |=> (mask_r == '0))
    else $error("mask not cleared");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (result.cell_count <= CNT_W'(CELLS)))
    else $error("cell count beyond cell total");

  a_low_below_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && result.low_valid) |->
      ((result.low_level <= result.high_level) && (result.cell_count != '0)))
    else $error("low level inconsistent with high level or count");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cmb_pkg::*;

  // request kind that leaves the state alone, and a register index with no register
  localparam logic [1:0] REQ_NOP   = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic [ID_W-1:0] ID_UNKNOWN = 11'h7FF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 190;

  class module_tracker;
    logic [LVL_W-1:0]  levels [8];
    logic [MASK_W-1:0] mask;
    logic [TEMP_W-1:0] temp;
    logic [ADDR_W-1:0] addr;
    logic [LVL_W-1:0]  ignore_lvl;
    cmb_result_t       pending_reports [$];
    int                failures;

    function new();
      levels = '{default: '0};
      mask = '0;
      temp = '0;
      addr = '0;
      ignore_lvl = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [LVL_W-1:0] data);
      case (idx)
        CFG_MODULE_ADDRESS: addr = data[ADDR_W-1:0];
        CFG_IGNORE_LEVEL:   ignore_lvl = data;
        default: ;
      endcase
    endfunction

    function int level_at(int c);
      if (c < 1 || c > 8) return 0;
      return int'(levels[c-1]);
    endfunction

    function void note_word(logic [1:0] req, logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] pl,
                            logic [LVL_W-1:0] pmin, logic [LVL_W-1:0] pmax);
      int per, first, i, v, lowest, min_cell, lo, hi, sum, cnt;
      bit spread, low_ok;
      cmb_result_t res;
      case (req)
        REQ_FRAME: begin
          per = (addr >= ADDR_WIDE_MIN && addr <= ADDR_WIDE_MAX) ? 4 : 3;
          if (id == ID_CELLS_LO || id == ID_CELLS_HI) begin
            first = (id == ID_CELLS_LO) ? 1 : 1 + per;
            for (int j = 0; j < per; j++) begin
              // high byte keeps only its low nibble
              v = {pl[16*j +: 4], pl[16*j+8 +: 8]};
              if (v != 0 && first + j <= 8) levels[first+j-1] = v[LVL_W-1:0];
            end
          end else if (id == ID_TEMP) begin
            temp = {pl[55:48], pl[63:56]};
          end
        end
        REQ_BALANCE: begin
          lowest = int'(LOW_LIMIT);
          min_cell = 0;
          spread = (int'(pmax) - int'(pmin)) > int'(SPREAD_GAP);
          i = 1;
          while (i <= 8) begin
            v = level_at(i);
            if (spread) begin
              if (mask[i-1]) begin
                if (!(v + int'(KEEP_MARGIN) > int'(pmin))) mask[i-1] = 1'b0;
              end else if (v == int'(pmax)) begin
                // a start skips the neighbor, which is then the one searched
                mask[i-1] = 1'b1;
                i++;
              end
            end else begin
              mask[i-1] = (v == int'(pmax));
            end
            v = level_at(i);
            if (v < lowest && v > 0) begin
              lowest = v;
              min_cell = i;
            end
            i++;
          end
          if ((mask == MASK_FULL8 || mask == MASK_FULL6) && min_cell >= 1)
            mask[min_cell-1] = 1'b0;
        end
        REQ_CLEAR: mask = '0;
        default: ;
      endcase

      lo = 0;
      hi = 0;
      sum = 0;
      cnt = 0;
      low_ok = 1'b0;
      for (int c = 1; c <= 8; c++) begin
        v = level_at(c);
        if (v > int'(ignore_lvl)) begin
          if (!mask[c-1] && (!low_ok || v < lo)) begin
            lo = v;
            low_ok = 1'b1;
          end
          if (v > hi) hi = v;
          sum += v;
          cnt++;
        end
      end
      res.balance_mask    = mask;
      res.low_level       = lo[LVL_W-1:0];
      res.low_valid       = low_ok;
      res.high_level      = hi[LVL_W-1:0];
      res.level_sum       = sum[SUM_W-1:0];
      res.cell_count      = cnt[CNT_W-1:0];
      res.temperature_raw = temp;
      pending_reports.push_back(res);
    endfunction

    function void check_field(string name, int e, int a);
      if (e != a) begin
        failures++;
        if (failures <= 10)
          $display("mismatch in %s: expected %0d, got %0d", name, e, a);
      end
    endfunction

    function void check_report(logic [OUT_TDATA_W-1:0] word);
      cmb_result_t e, a;
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result word with nothing expected: %h", word);
        return;
      end
      e = pending_reports.pop_front();
      a = cmb_result_t'(word[$bits(cmb_result_t)-1:0]);
      check_field("balance_mask", e.balance_mask, a.balance_mask);
      check_field("low_level", e.low_level, a.low_level);
      check_field("low_valid", e.low_valid, a.low_valid);
      check_field("high_level", e.high_level, a.high_level);
      check_field("level_sum", e.level_sum, a.level_sum);
      check_field("cell_count", e.cell_count, a.cell_count);
      check_field("temperature_raw", e.temperature_raw, a.temperature_raw);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [LVL_W-1:0] cfg_wdata = '0;
  wire in_tready;
  wire out_tvalid;
  wire [OUT_TDATA_W-1:0] out_tdata;

  bit stall_en = 1'b1;
  int cycles = 0;
  logic [LVL_W-1:0] pool [4];
  module_tracker tracker = new();

  initial begin
    forever #6 clk = ~clk;
  end

  cell_monitor_with_balancing uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready)
        tracker.note_word(in_tuser, in_tdata[10:0], in_tdata[74:11], in_tdata[86:75],
                          in_tdata[98:87]);
      if (out_tvalid && out_tready) tracker.check_report(out_tdata);
    end
  end

  always @(negedge clk) begin
    out_tready <= !stall_en || ($urandom_range(99) >= 28);
  end

  function automatic logic [PAYLOAD_W-1:0] cell_payload(logic [LVL_W-1:0] a, logic [LVL_W-1:0] b,
                                                        logic [LVL_W-1:0] c, logic [LVL_W-1:0] d);
    logic [LVL_W-1:0] lv [4];
    logic [PAYLOAD_W-1:0] pl;
    lv = '{a, b, c, d};
    for (int j = 0; j < 4; j++) begin
      // junk in the upper nibble of the high byte must be dropped
      pl[16*j +: 8]   = {4'($urandom), lv[j][11:8]};
      pl[16*j+8 +: 8] = lv[j][7:0];
    end
    return pl;
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 15) return LVL_W'($urandom_range(1, 40));
    if (r < 35) return LVL_W'($urandom_range(3985, 4015));
    return LVL_W'($urandom_range(1, 4095));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic [1:0] req, logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] pl,
                           logic [LVL_W-1:0] pmin, logic [LVL_W-1:0] pmax);
    while (stall_en && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'd0, pmax, pmin, pl, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [LVL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic random_word();
    int kind, r, pm;
    logic [1:0] req;
    logic [ID_W-1:0] id;
    logic [PAYLOAD_W-1:0] pl;
    logic [LVL_W-1:0] pmin, pmax;
    logic [LVL_W-1:0] lv [4];
    if ($urandom_range(99) < 3) pool[$urandom_range(3)] = pick_level();
    kind = $urandom_range(99);
    req  = REQ_FRAME;
    id   = ID_W'($urandom);
    pl   = {$urandom, $urandom};
    pmin = LVL_W'($urandom);
    pmax = LVL_W'($urandom);
    if (kind < 40) begin
      id = $urandom_range(1) ? ID_CELLS_HI : ID_CELLS_LO;
      for (int j = 0; j < 4; j++) begin
        r = $urandom_range(99);
        if (r < 70) lv[j] = pool[$urandom_range(3)];
        else if (r < 85) lv[j] = '0;
        else lv[j] = LVL_W'($urandom);
      end
      pl = cell_payload(lv[0], lv[1], lv[2], lv[3]);
    end else if (kind < 45) begin
      id = ID_TEMP;
    end else if (kind < 75) begin
      req = REQ_BALANCE;
      r = $urandom_range(99);
      if (r < 60) pmax = pool[$urandom_range(3)];
      else if (r < 80) pmax = tracker.levels[$urandom_range(7)];
      if ($urandom_range(99) < 60) begin
        pm = int'(pmax) - int'($urandom_range(80));
        pmin = (pm < 0) ? '0 : LVL_W'(pm);
      end
    end else if (kind < 82) begin
      req = REQ_CLEAR;
    end else if (kind < 87) begin
      req = REQ_NOP;
    end else if (kind >= 94) begin
      req = 2'($urandom);
    end
    send_word(req, id, pl, pmin, pmax);
  endtask

  initial begin
    int addr_set [6];
    int ign_set [6];
    addr_set = '{2, 11, 12, 1, 63, 0};
    ign_set  = '{0, 1500, 0, 3999, 4095, 0};
    ign_set[5] = $urandom_range(4095);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: 6-cell frames
    send_word(REQ_NOP, ID_W'($urandom), {$urandom, $urandom}, 12'hFFF, 12'hFFF);
    send_word(REQ_FRAME, ID_CELLS_LO, cell_payload(1000, 1001, 1002, 1003), 0, 0);
    send_word(REQ_FRAME, ID_CELLS_HI, cell_payload(1004, 1005, 4095, 7), 0, 0);
    drain();
    write_reg(CFG_MODULE_ADDRESS, 12'hFC2);
    write_reg(CFG_IGNORE_LEVEL, 12'd0);

    // 8-cell frames, zero levels skipped
    send_word(REQ_FRAME, ID_CELLS_HI, cell_payload(0, 2000, 1, 1006), 0, 0);
    send_word(REQ_FRAME, ID_TEMP, 64'hCDAB_FFFF_FFFF_FFFF, 0, 0);
    send_word(REQ_FRAME, ID_UNKNOWN, '1, '1, '1);
    // spread start with skip, then equal mode from a negative spread
    send_word(REQ_BALANCE, '0, '0, 12'd900, 12'd2000);
    send_word(REQ_BALANCE, '0, '0, 12'd1003, 12'd1001);
    send_word(REQ_BALANCE, '0, '0, 12'd0, 12'd1002);
    send_word(REQ_BALANCE, '0, '0, 12'd1500, 12'd4095);
    send_word(REQ_CLEAR, '1, '1, '1, '1);
    // full mask frees the lowest cell
    send_word(REQ_FRAME, ID_CELLS_LO, cell_payload(3000, 3000, 3000, 3000), 0, 0);
    send_word(REQ_FRAME, ID_CELLS_HI, cell_payload(3000, 3000, 3000, 3000), 0, 0);
    send_word(REQ_BALANCE, '0, '0, 12'd3000, 12'd3000);
    // full mask with every level above the search limit stays full
    send_word(REQ_FRAME, ID_CELLS_LO, cell_payload(4050, 4050, 4050, 4050), 0, 0);
    send_word(REQ_FRAME, ID_CELLS_HI, cell_payload(4050, 4050, 4050, 4050), 0, 0);
    send_word(REQ_BALANCE, '0, '0, 12'd4050, 12'd4050);
    send_word(REQ_BALANCE, '0, '0, 12'd0, 12'd4095);
    send_word(REQ_NOP, '0, '0, '0, '0);
    drain();
    write_reg(CFG_MODULE_ADDRESS, 12'd12);
    write_reg(CFG_IGNORE_LEVEL, 12'd4095);
    write_reg(CFG_SPARE, 12'hFFF);

    // 6-cell full mask
    send_word(REQ_FRAME, ID_CELLS_LO, cell_payload(500, 500, 500, 4095), 0, 0);
    send_word(REQ_FRAME, ID_CELLS_HI, cell_payload(500, 500, 500, 4095), 0, 0);
    send_word(REQ_BALANCE, '0, '0, 12'd500, 12'd500);
    send_word(REQ_CLEAR, '0, '0, '0, '0);
    send_word(REQ_FRAME, ID_CELLS_LO, '1, '0, '0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_MODULE_ADDRESS, {6'($urandom), 6'(addr_set[p])});
      write_reg(CFG_IGNORE_LEVEL, LVL_W'(ign_set[p]));
      stall_en = (p != 2);
      for (int k = 0; k < 4; k++) pool[k] = pick_level();
      repeat (PHASE_WORDS) random_word();
      drain();
    end

    stall_en = 1'b1;
    repeat (10) @(negedge clk);
    if (tracker.failures == 0 && tracker.pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
